FILE: rtl/fbe_pkg.sv
// ----------------------------------------------------------------------------
// fbe_pkg
// Shared types, sizes and helper functions of the RGB565 frame store.
// ----------------------------------------------------------------------------
package fbe_pkg;

  // Panel geometry
  localparam int PANEL_WIDTH  = 480;
  localparam int PANEL_HEIGHT = 320;
  localparam int PIXELS       = PANEL_WIDTH * PANEL_HEIGHT;

  // Field widths fixed by the interface
  localparam int COORD_W = 10;
  localparam int COLOR_W = 16;
  localparam int CH_W    = 8;
  localparam int POS_W   = 9;
  localparam int CMP_W   = COORD_W + 1;

  // Internal widths that follow from the geometry
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int COL_W  = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
  localparam int ROW_W  = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

  // Reciprocal constants for the color expansion
  // floor(n / 31) == (n * 265) >> 13 for n <= 217, folded with 7x: 7 * 265
  localparam int RECIP_R5 = 1855;
  // floor(x / 21) == (x * 49) >> 10 for x <= 63
  localparam int RECIP_G6 = 49;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FILL  = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  opcode;
    logic [COORD_W-1:0]   x_start;
    logic [COORD_W-1:0]   y_start;
    logic [COORD_W-1:0]   x_end;
    logic [COORD_W-1:0]   y_end;
    logic [COLOR_W-1:0]   write_color;
  } cmd_t;

  typedef struct packed {
    logic                 status;
    logic [COLOR_W-1:0]   read_color;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic [POS_W-1:0]     scan_column;
    logic [POS_W-1:0]     scan_row;
    logic                 frame_end;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [COLOR_W-1:0]   wdata;
  } ram_req_t;

  function automatic logic on_panel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    return ({1'b0, x} < CMP_W'(PANEL_WIDTH)) && ({1'b0, y} < CMP_W'(PANEL_HEIGHT));
  endfunction

  function automatic logic [ADDR_W-1:0] pixel_addr(logic [COL_W-1:0] col,
                                                   logic [ROW_W-1:0] row);
    return ADDR_W'(row) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(col);
  endfunction

  // v * 255 / 31 == 8v + floor(7v / 31)
  function automatic logic [CH_W-1:0] expand5(logic [4:0] v);
    logic [16:0] p;
    p = 17'(v) * 17'(RECIP_R5);
    return {v, 3'b000} + CH_W'(p[16:13]);
  endfunction

  // v * 255 / 63 == 4v + floor(v / 21)
  function automatic logic [CH_W-1:0] expand6(logic [5:0] v);
    logic [11:0] p;
    p = 12'(v) * 12'(RECIP_G6);
    return {v, 2'b00} + CH_W'(p[11:10]);
  endfunction

endpackage

FILE: rtl/fbe_ram.sv
// ----------------------------------------------------------------------------
// fbe_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fbe_seq.sv
// ----------------------------------------------------------------------------
// fbe_seq
// Command sequencer: clearing pass, pixel access, rectangle walk and scan.
// ----------------------------------------------------------------------------
module fbe_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  fbe_pkg::cmd_t     cmd_i,
  output logic              cmd_stall_o,
  output logic              res_valid_o,
  output fbe_pkg::res_t     res_o,
  input  logic              res_take_i,
  output fbe_pkg::ram_req_t ram_req_o,
  input  logic [fbe_pkg::COLOR_W-1:0] ram_rdata_i
);
  import fbe_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_FILL,
    ST_READ,
    ST_PUSH
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  res_t              res_q, res_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  scan_col_q, scan_col_d;
  logic [ROW_W-1:0]  scan_row_q, scan_row_d;

  always_comb begin
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    state_d    = state_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    clr_addr_d = clr_addr_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    scan_col_d = scan_col_q;
    scan_row_d = scan_row_q;
    ram_req_o  = '0;
    col        = '0;
    row        = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_req_o.we   = 1'b1;
        ram_req_o.addr = clr_addr_q;
        clr_addr_d     = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(PIXELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        res_d = '0;
        unique case (cmd_q.opcode)
          OP_WRITE: begin
            if (on_panel(cmd_q.x_start, cmd_q.y_start)) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.addr  = pixel_addr(COL_W'(cmd_q.x_start), ROW_W'(cmd_q.y_start));
              ram_req_o.wdata = cmd_q.write_color;
            end else begin
              res_d.status = 1'b1;
            end
            state_d = ST_PUSH;
          end
          OP_READ: begin
            if (on_panel(cmd_q.x_start, cmd_q.y_start)) begin
              ram_req_o.addr = pixel_addr(COL_W'(cmd_q.x_start), ROW_W'(cmd_q.y_start));
              state_d        = ST_READ;
            end else begin
              res_d.status = 1'b1;
              state_d      = ST_PUSH;
            end
          end
          OP_FILL: begin
            if (!on_panel(cmd_q.x_start, cmd_q.y_start) ||
                !on_panel(cmd_q.x_end, cmd_q.y_end)) begin
              res_d.status = 1'b1;
              state_d      = ST_PUSH;
            end else if ((cmd_q.x_start > cmd_q.x_end) ||
                         (cmd_q.y_start > cmd_q.y_end)) begin
              state_d = ST_PUSH;
            end else begin
              cur_col_d = COL_W'(cmd_q.x_start);
              cur_row_d = ROW_W'(cmd_q.y_start);
              state_d   = ST_FILL;
            end
          end
          OP_SCAN: begin
            // Restart at the origin if the position ever left the panel
            if (({1'b0, scan_col_q} < (COL_W + 1)'(PANEL_WIDTH)) &&
                ({1'b0, scan_row_q} < (ROW_W + 1)'(PANEL_HEIGHT))) begin
              col = scan_col_q;
              row = scan_row_q;
            end
            ram_req_o.addr    = pixel_addr(col, row);
            res_d.scan_column = POS_W'(col);
            res_d.scan_row    = POS_W'(row);
            res_d.frame_end   = (col == COL_W'(PANEL_WIDTH - 1)) &&
                                (row == ROW_W'(PANEL_HEIGHT - 1));
            if (col != COL_W'(PANEL_WIDTH - 1)) begin
              scan_col_d = col + 1'b1;
              scan_row_d = row;
            end else if (row != ROW_W'(PANEL_HEIGHT - 1)) begin
              scan_col_d = '0;
              scan_row_d = row + 1'b1;
            end else begin
              scan_col_d = '0;
              scan_row_d = '0;
            end
            state_d = ST_READ;
          end
          default: state_d = ST_PUSH;
        endcase
      end
      ST_FILL: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = pixel_addr(cur_col_q, cur_row_q);
        ram_req_o.wdata = cmd_q.write_color;
        if (cur_col_q == COL_W'(cmd_q.x_end)) begin
          if (cur_row_q == ROW_W'(cmd_q.y_end)) begin
            state_d = ST_PUSH;
          end else begin
            cur_col_d = COL_W'(cmd_q.x_start);
            cur_row_d = cur_row_q + 1'b1;
          end
        end else begin
          cur_col_d = cur_col_q + 1'b1;
        end
      end
      ST_READ: begin
        res_d.read_color = ram_rdata_i;
        if (cmd_q.opcode == OP_SCAN) begin
          res_d.red   = expand5(ram_rdata_i[15:11]);
          res_d.green = expand6(ram_rdata_i[10:5]);
          res_d.blue  = expand5(ram_rdata_i[4:0]);
        end
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      scan_col_q <= '0;
      scan_row_q <= '0;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      cmd_q      <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      scan_col_q <= scan_col_d;
      scan_row_q <= scan_row_d;
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      cmd_q      <= cmd_d;
      res_q      <= res_d;
    end
  end

  assign cmd_stall_o = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_PUSH);
  assign res_o       = res_q;

endmodule

FILE: rtl/rgb565_framebuffer_engine_unit.sv
// ----------------------------------------------------------------------------
// rgb565_framebuffer_engine_unit
// RGB565 frame store with pixel write/read, rectangle fill and raster scan.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: in_valid_i / in_stall_o with opcode_i, x_start_i,
//   y_start_i, x_end_i, y_end_i and write_color_i. A beat is taken at a
//   rising edge with in_valid_i high and in_stall_o low.
//   Result channel: out_valid_o / out_stall_i with status_o, read_color_o,
//   red_o, green_o, blue_o, scan_column_o, scan_row_o and frame_end_o. Every
//   command yields exactly one result beat, in command order.
//   Sequence: one command is in flight at a time. A write or a rejected
//   command goes from acceptance straight to its result, a read or scan
//   passes through an extra state for the registered RAM read, and a fill
//   walks the covered pixels, since the single RAM port writes one pixel
//   per cycle. The next command is taken once its result has been handed on.
//   Reset: rst_ni clears the control state, then a clearing pass writes zero
//   to all 153600 pixels, one per cycle; in_stall_o stays high throughout
//   the pass.
//   Stall: the result register holds its beat while out_stall_i is high; the
//   sequencer can still accept and finish one more command meanwhile and
//   holds that result until the register frees up.
// ----------------------------------------------------------------------------
module rgb565_framebuffer_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [fbe_pkg::COORD_W-1:0]  x_start_i,
  input  logic [fbe_pkg::COORD_W-1:0]  y_start_i,
  input  logic [fbe_pkg::COORD_W-1:0]  x_end_i,
  input  logic [fbe_pkg::COORD_W-1:0]  y_end_i,
  input  logic [fbe_pkg::COLOR_W-1:0]  write_color_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic [fbe_pkg::COLOR_W-1:0]  read_color_o,
  output logic [fbe_pkg::CH_W-1:0]     red_o,
  output logic [fbe_pkg::CH_W-1:0]     green_o,
  output logic [fbe_pkg::CH_W-1:0]     blue_o,
  output logic [fbe_pkg::POS_W-1:0]    scan_column_o,
  output logic [fbe_pkg::POS_W-1:0]    scan_row_o,
  output logic                         frame_end_o
);
  import fbe_pkg::*;

  cmd_t              cmd;
  res_t              seq_res;
  logic              seq_res_valid;
  logic              res_take;
  ram_req_t          ram_req;
  logic [COLOR_W-1:0] ram_rdata;

  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Pack the command beat
  always_comb begin
    cmd.opcode      = op_e'(opcode_i);
    cmd.x_start     = x_start_i;
    cmd.y_start     = y_start_i;
    cmd.x_end       = x_end_i;
    cmd.y_end       = y_end_i;
    cmd.write_color = write_color_i;
  end

  fbe_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_valid_i),
    .cmd_i       (cmd),
    .cmd_stall_o (in_stall_o),
    .res_valid_o (seq_res_valid),
    .res_o       (seq_res),
    .res_take_i  (res_take),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Pixel store, one word per pixel, row-major
  fbe_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // Result register: load when empty or when the held beat leaves now
  assign res_take = seq_res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_d       = seq_res;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign read_color_o  = out_q.read_color;
  assign red_o         = out_q.red;
  assign green_o       = out_q.green;
  assign blue_o        = out_q.blue;
  assign scan_column_o = out_q.scan_column;
  assign scan_row_o    = out_q.scan_row;
  assign frame_end_o   = out_q.frame_end;

endmodule
